[rtl/assert_macros.svh]
// Assertion macros for the checker file of the overlap counter.
// Each macro expects signals named clk and arst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SGOC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SGOC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

[rtl/sgoc_pkg.sv]
// Shared types and constants of the segment grid overlap counter.
// No dependencies; used by every module of the block.
package sgoc_pkg;

	localparam int COORD_W       = 10;
	localparam int TOTAL_W       = 21;
	localparam int HITS_W        = 2;
	localparam int LIM_W         = 13;
	localparam int GRID_SIZE_DEF = 1024;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
	localparam logic [HITS_W-1:0]  HITS_ONE  = 2'd1;
	localparam logic [HITS_W-1:0]  HITS_SAT  = 2'd2;

	// Control that travels with each cell access through the pipeline.
	typedef struct packed {
		logic valid;
		logic in_grid;
		logic last;
	} cell_ctl_t;

endpackage

[rtl/segment_grid_overlap_counter.sv]
// Top level of the segment grid overlap counter.
// Depends on sgoc_pkg, sgoc_walker, sgoc_cell_mem and sgoc_tally.
//
// Usage: a segment is offered on start_x/start_y/end_x/end_y with start high;
// the transfer takes place at a rising edge where start is high and busy is
// low. The block then walks the covered grid cells, one per clock, through a
// read-modify-write of the hit-count memory (read registered, write in the cycle
// after). Horizontal and vertical segments cover all cells between their
// endpoints; any other segment is walked diagonally until one coordinate
// reaches its end. Cells outside the grid are walked over but not counted.
//
// A segment is accepted; when its last cell has left the write-back stage,
// done pulses for one cycle from its register with overlap_cells, the running
// count of cells hit at least twice. busy stays high until then, so a new
// segment can be taken in the cycle of done; cells go one per cycle through the
// single memory port pair. The receiver cannot refuse the result transfer.
//
// After reset the memory is cleared one cell a cycle, which covers all
// 2^(2*clog2(GRID_SIZE)) cells (1048576 at the default size); busy is high
// throughout. The overlap total is cleared at once and saturates at its max.
module segment_grid_overlap_counter #(
	parameter int GRID_SIZE = sgoc_pkg::GRID_SIZE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [sgoc_pkg::COORD_W-1:0]   start_x,
	input  logic [sgoc_pkg::COORD_W-1:0]   start_y,
	input  logic [sgoc_pkg::COORD_W-1:0]   end_x,
	input  logic [sgoc_pkg::COORD_W-1:0]   end_y,
	output logic                           done,
	output logic [sgoc_pkg::TOTAL_W-1:0]   overlap_cells
);

	localparam int MAW = 2 * $clog2(GRID_SIZE);

	sgoc_pkg::cell_ctl_t          walk_ctl;
	logic [MAW-1:0]               walk_addr;
	logic [sgoc_pkg::HITS_W-1:0]  rd_data;
	logic                         wr_en;
	logic [MAW-1:0]               wr_addr;
	logic [sgoc_pkg::HITS_W-1:0]  wr_data;
	logic                         clearing;
	logic                         s1_busy;
	logic                         accept;

	// Busy covers the clearing sweep, the walk and the write-back stage.
	assign busy   = clearing || walk_ctl.valid || s1_busy;
	assign accept = start && !busy;

	sgoc_walker #(.GRID_SIZE(GRID_SIZE)) u_walker (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (accept),
		.start_x (start_x),
		.start_y (start_y),
		.end_x   (end_x),
		.end_y   (end_y),
		.ctl     (walk_ctl),
		.addr    (walk_addr)
	);

	sgoc_cell_mem #(.GRID_SIZE(GRID_SIZE)) u_cell_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr  (walk_addr),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.clearing (clearing)
	);

	sgoc_tally #(.GRID_SIZE(GRID_SIZE)) u_tally (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (walk_ctl),
		.addr    (walk_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.s1_busy (s1_busy),
		.done    (done),
		.total   (overlap_cells)
	);

endmodule

[rtl/sgoc_walker.sv]
// Cell address generator: walks one segment, one cell per cycle.
// Depends on sgoc_pkg.
module sgoc_walker #(
	parameter int GRID_SIZE = sgoc_pkg::GRID_SIZE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           load,
	input  logic [sgoc_pkg::COORD_W-1:0]   start_x,
	input  logic [sgoc_pkg::COORD_W-1:0]   start_y,
	input  logic [sgoc_pkg::COORD_W-1:0]   end_x,
	input  logic [sgoc_pkg::COORD_W-1:0]   end_y,
	output sgoc_pkg::cell_ctl_t            ctl,
	output logic [2*$clog2(GRID_SIZE)-1:0] addr
);

	localparam int AW = $clog2(GRID_SIZE);
	localparam logic [sgoc_pkg::LIM_W-1:0] GridLim = sgoc_pkg::LIM_W'(GRID_SIZE);

	logic                         active_q;
	logic [sgoc_pkg::COORD_W-1:0] cx_q, cy_q, ex_q, ey_q;
	logic                         mvx_q, mvy_q, upx_q, upy_q;
	logic                         last;

	// A segment ends when a moving coordinate reaches its end; a point ends at once.
	assign last = (mvx_q && (cx_q == ex_q)) || (mvy_q && (cy_q == ey_q)) ||
		(!mvx_q && !mvy_q);

	always_comb begin
		ctl.valid   = active_q;
		ctl.last    = last;
		ctl.in_grid = (sgoc_pkg::LIM_W'(cx_q) < GridLim) &&
			(sgoc_pkg::LIM_W'(cy_q) < GridLim);
		addr        = {AW'(cy_q), AW'(cx_q)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (load) begin
			active_q <= 1'b1;
		end else if (active_q && last) begin
			active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cx_q  <= start_x;
			cy_q  <= start_y;
			ex_q  <= end_x;
			ey_q  <= end_y;
			mvx_q <= (start_x != end_x);
			mvy_q <= (start_y != end_y);
			upx_q <= (end_x > start_x);
			upy_q <= (end_y > start_y);
		end else if (active_q) begin
			if (mvx_q) begin
				cx_q <= upx_q ? cx_q + 1'b1 : cx_q - 1'b1;
			end
			if (mvy_q) begin
				cy_q <= upy_q ? cy_q + 1'b1 : cy_q - 1'b1;
			end
		end
	end

endmodule

[rtl/sgoc_cell_mem.sv]
// Hit-count memory with one registered read port, one write port and a
// clearing sweep after reset. Depends on sgoc_pkg.
module sgoc_cell_mem #(
	parameter int GRID_SIZE = sgoc_pkg::GRID_SIZE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [2*$clog2(GRID_SIZE)-1:0] rd_addr,
	output logic [sgoc_pkg::HITS_W-1:0]    rd_data,
	input  logic                           wr_en,
	input  logic [2*$clog2(GRID_SIZE)-1:0] wr_addr,
	input  logic [sgoc_pkg::HITS_W-1:0]    wr_data,
	output logic                           clearing
);

	localparam int MAW   = 2 * $clog2(GRID_SIZE);
	localparam int DEPTH = 1 << MAW;

	logic [sgoc_pkg::HITS_W-1:0] mem [DEPTH];
	logic [sgoc_pkg::HITS_W-1:0] rd_data_q;
	logic [MAW-1:0]              clr_addr_q;
	logic                        clearing_q;

	assign rd_data  = rd_data_q;
	assign clearing = clearing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == {MAW{1'b1}}) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

endmodule

[rtl/sgoc_tally.sv]
// Modify and write-back stage: bumps the hit count, keeps the overlap total
// and raises the result strobe. Depends on sgoc_pkg.
module sgoc_tally #(
	parameter int GRID_SIZE = sgoc_pkg::GRID_SIZE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sgoc_pkg::cell_ctl_t            ctl,
	input  logic [2*$clog2(GRID_SIZE)-1:0] addr,
	input  logic [sgoc_pkg::HITS_W-1:0]    rd_data,
	output logic                           wr_en,
	output logic [2*$clog2(GRID_SIZE)-1:0] wr_addr,
	output logic [sgoc_pkg::HITS_W-1:0]    wr_data,
	output logic                           s1_busy,
	output logic                           done,
	output logic [sgoc_pkg::TOTAL_W-1:0]   total
);

	localparam int MAW = 2 * $clog2(GRID_SIZE);

	sgoc_pkg::cell_ctl_t           ctl_s1;
	logic [MAW-1:0]                addr_s1;
	logic [sgoc_pkg::TOTAL_W-1:0]  total_q;
	logic                          done_q;
	logic                          bump;

	// Cells are distinct within a segment and segments do not overlap in
	// time, so the read in flight never targets the cell being written.
	assign bump    = ctl_s1.valid && ctl_s1.in_grid && (rd_data < sgoc_pkg::HITS_SAT);
	assign wr_en   = bump;
	assign wr_addr = addr_s1;
	assign wr_data = rd_data + 1'b1;
	assign s1_busy = ctl_s1.valid;
	assign done    = done_q;
	assign total   = total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1  <= '0;
			total_q <= '0;
			done_q  <= 1'b0;
		end else begin
			ctl_s1 <= ctl;
			done_q <= ctl_s1.valid && ctl_s1.last;
			if (bump && (rd_data == sgoc_pkg::HITS_ONE) &&
				(total_q != sgoc_pkg::TOTAL_MAX)) begin
				total_q <= total_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr;
	end

endmodule

[rtl/sgoc_checker.sv]
// Port-level checks of the segment grid overlap counter, bound to the top.
// Depends on sgoc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sgoc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic [sgoc_pkg::TOTAL_W-1:0] overlap_cells
);

	// An accepted segment keeps the block busy in the following cycle.
	`SGOC_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	// Every segment takes at least one cell, so results never come back to back.
	`SGOC_ASSERT_NEXT(a_done_single, done, !done)
	// The result is shown only once the write-back has drained.
	`SGOC_ASSERT_NOW(a_done_idle, done, !busy)
	// With nothing in flight the running total cannot move.
	`SGOC_ASSERT_NEXT(a_idle_total, !busy, $stable(overlap_cells))

endmodule

bind segment_grid_overlap_counter sgoc_checker u_sgoc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.overlap_cells (overlap_cells)
);
